>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the calendar converter checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The antecedent must be followed by the consequent sequence.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");

`endif

>>> src/ttc_pkg.sv
// ----------------------------------------------------------------------------
// Calendar converter package
// Constants, widths and small tables shared by the converter modules.
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int TS_W         = 32;
    localparam int SECS_PER_DAY = 86400;
    localparam int SECS_PER_HR  = 3600;
    localparam int SECS_PER_MIN = 60;

    // The day split divides the timestamp by 128 first, then by the odd rest.
    localparam int DAY_SHIFT = 7;
    localparam int DAY_DIV   = SECS_PER_DAY >> DAY_SHIFT;
    localparam int DAY_XW    = TS_W - DAY_SHIFT;
    localparam int DAYS_W    = 16;
    localparam int DAY_RW    = 10;
    localparam int RSEC_W    = DAY_RW + DAY_SHIFT;

    localparam int DAYS_400Y = 365 * 400 + 97;
    localparam int DAYS_100Y = 365 * 100 + 24;
    localparam int DAYS_4Y   = 365 * 4 + 1;
    localparam int DAYS_1Y   = 365;
    localparam int DAYS_JAN_FEB = 31 + 28;

    // Days from 1970-01-01 to 2000-03-01.
    localparam int EPOCH_DAYS = (946684800 + SECS_PER_DAY * (31 + 29)) / SECS_PER_DAY;
    // Adding one 400-year cycle keeps the shifted day count non-negative.
    localparam int DAY_BIAS  = DAYS_400Y - EPOCH_DAYS;
    localparam int WDAY_BIAS = ((3 - EPOCH_DAYS) % 7 + 7) % 7;

    localparam int R400_W = 18;
    localparam int R100_W = 16;
    localparam int R4_W   = 11;
    localparam int RDAY_W = 9;
    localparam int QQ_W   = 5;
    localparam int HOUR_W = 5;
    localparam int HREM_W = 12;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int YEAR_W = 12;
    localparam int MIDX_W = 4;

    localparam int YEAR_BASE_HI = 2000;
    localparam int YEAR_BASE_LO = YEAR_BASE_HI - 400;
    // Month index counted from March; January is index ten.
    localparam int MIDX_JAN = 10;

    // First day of each month, counted from March 1.
    function automatic logic [RDAY_W-1:0] month_start(input logic [MIDX_W-1:0] m);
        logic [RDAY_W-1:0] s;
        case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // Remainder by seven through folding of octal digits, since 8 is 1 mod 7.
    function automatic logic [2:0] mod7(input logic [17:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = '0;
        for (int i = 0; i < 6; i++) begin
            s1 = s1 + 6'(v[3*i +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

endpackage

>>> src/ttc_cdiv.sv
// ----------------------------------------------------------------------------
// Constant divider
// Two-stage unsigned divide by a constant: reciprocal multiply, then one
// compare-and-subtract correction. Quotient and remainder are both registered.
// ----------------------------------------------------------------------------
module ttc_cdiv #(
    parameter int XW      = ttc_pkg::DAY_XW,
    parameter int QW      = ttc_pkg::DAYS_W,
    parameter int RW      = ttc_pkg::DAY_RW,
    parameter int DIVISOR = ttc_pkg::DAY_DIV
) (
    input  logic          clk,
    input  logic [XW-1:0] x,
    output logic [QW-1:0] q,
    output logic [RW-1:0] r
);

    localparam int MW = XW - $clog2(DIVISOR) + 1;
    localparam int PW = XW + MW;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << XW) / DIVISOR);

    logic [PW-1:0] prod;
    logic [QW-1:0] q0_reg;
    logic [QW-1:0] q0_next;
    logic [XW-1:0] x_reg;
    logic [XW-1:0] r0;
    logic [QW-1:0] q_reg;
    logic [QW-1:0] q_next;
    logic [RW-1:0] r_reg;
    logic [RW-1:0] r_next;

    // The truncated reciprocal undershoots by less than one, so the estimate
    // is the quotient or one below it.
    assign prod    = PW'(x) * PW'(RECIP);
    assign q0_next = prod[XW +: QW];

    always_comb
    begin
        r0 = x_reg - XW'(q0_reg * DIVISOR);
        if (r0 >= XW'(DIVISOR))
        begin
            q_next = q0_reg + QW'(1);
            r_next = RW'(r0 - XW'(DIVISOR));
        end
        else
        begin
            q_next = q0_reg;
            r_next = RW'(r0);
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        x_reg  <= x;
        q_reg  <= q_next;
        r_reg  <= r_next;
    end

    assign q = q_reg;
    assign r = r_reg;

endmodule

>>> src/timestamp_to_calendar.sv
// ----------------------------------------------------------------------------
// Unix timestamp to Gregorian calendar converter
// Splits a 32-bit Unix time into date, time of day, weekday and day of year.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   input    | start / busy       | timestamp
//   result   | done (one cycle)   | year, month, day_of_month, hour, minute,
//            |                    | second, day_of_week, day_of_year
//
// One beat is taken in every cycle; busy is always low.
// Each result passes through these stages after its input beat: two stages each for the
// day and four-year dividers, one each for the 400-year split, the century,
// the year, the month search and the output register.
// Reset clears only the valid pipeline; data registers are not reset.
// The result is shown for one cycle under done and cannot be held off.
// ----------------------------------------------------------------------------
module timestamp_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] timestamp,
    output logic        done,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [2:0]  day_of_week,
    output logic [8:0]  day_of_year
);

    localparam int LAT = 9;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    // Stages one and two: day split.
    logic [ttc_pkg::DAY_SHIFT-1:0] lo1_reg;
    logic [ttc_pkg::DAY_SHIFT-1:0] lo2_reg;
    logic [ttc_pkg::DAYS_W-1:0]    day_q;
    logic [ttc_pkg::DAY_RW-1:0]    day_r;

    // Stage three: 400-year cycle and weekday.
    logic [ttc_pkg::R400_W-1:0] bias;
    logic                       qc_next;
    logic [ttc_pkg::R400_W-1:0] r400_next;
    logic [2:0]                 wday_next;
    logic                       qc3_reg;
    logic [ttc_pkg::R400_W-1:0] r400_reg;
    logic [2:0]                 wday3_reg;
    logic [ttc_pkg::RSEC_W-1:0] rsec_reg;

    // Stage four: century.
    logic [1:0]                 cc_next;
    logic [ttc_pkg::R400_W-1:0] r100_full;
    logic                       qc4_reg;
    logic [1:0]                 cc4_reg;
    logic [ttc_pkg::R100_W-1:0] r100_reg;
    logic [2:0]                 wday4_reg;
    logic [ttc_pkg::HOUR_W-1:0] hour_q;
    logic [ttc_pkg::HREM_W-1:0] hour_r;

    // Stages five and six: alignment with the four-year and minute dividers.
    logic                       qc5_reg;
    logic [1:0]                 cc5_reg;
    logic [2:0]                 wday5_reg;
    logic                       qc6_reg;
    logic [1:0]                 cc6_reg;
    logic [2:0]                 wday6_reg;
    logic [ttc_pkg::HOUR_W-1:0] hour6_reg;
    logic [ttc_pkg::QQ_W-1:0]   qq;
    logic [ttc_pkg::R4_W-1:0]   r4;
    logic [ttc_pkg::MIN_W-1:0]  min_q;
    logic [ttc_pkg::SEC_W-1:0]  sec_r;

    // Stage seven: year within the four-year cycle.
    logic [1:0]                 ry;
    logic [ttc_pkg::RDAY_W-1:0] rday_next;
    logic                       leap_next;
    logic [ttc_pkg::YEAR_W-1:0] year_next;
    logic [ttc_pkg::YEAR_W-1:0] year7_reg;
    logic [ttc_pkg::RDAY_W-1:0] rday7_reg;
    logic                       leap7_reg;
    logic [2:0]                 wday7_reg;
    logic [ttc_pkg::HOUR_W-1:0] hour7_reg;

    // Stage eight: month search and day of year.
    logic [ttc_pkg::MIDX_W-1:0] midx_next;
    logic [9:0]                 ysum;
    logic [9:0]                 ylim;
    logic [8:0]                 yday_next;
    logic [ttc_pkg::YEAR_W-1:0] year8_reg;
    logic [ttc_pkg::MIDX_W-1:0] midx8_reg;
    logic [ttc_pkg::RDAY_W-1:0] rday8_reg;
    logic [8:0]                 yday8_reg;
    logic [2:0]                 wday8_reg;
    logic [ttc_pkg::HOUR_W-1:0] hour8_reg;
    logic [ttc_pkg::MIN_W-1:0]  min8_reg;
    logic [ttc_pkg::SEC_W-1:0]  sec8_reg;

    // Output stage.
    logic                       jan_feb;
    logic [11:0] year_out_next;
    logic [3:0]  month_out_next;
    logic [4:0]  dom_out_next;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  dom_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [2:0]  wday_reg;
    logic [8:0]  yday_reg;

    assign busy     = 1'b0;
    assign vld_next = {vld_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ---- Stages one and two ----
    ttc_cdiv #(
        .XW      (ttc_pkg::DAY_XW),
        .QW      (ttc_pkg::DAYS_W),
        .RW      (ttc_pkg::DAY_RW),
        .DIVISOR (ttc_pkg::DAY_DIV)
    ) u_day_div (
        .clk (clk),
        .x   (timestamp[ttc_pkg::TS_W-1:ttc_pkg::DAY_SHIFT]),
        .q   (day_q),
        .r   (day_r)
    );

    always_ff @(posedge clk)
    begin
        lo1_reg <= timestamp[ttc_pkg::DAY_SHIFT-1:0];
        lo2_reg <= lo1_reg;
    end

    // ---- Stage three ----
    always_comb
    begin
        bias    = ttc_pkg::R400_W'(day_q) + ttc_pkg::R400_W'(ttc_pkg::DAY_BIAS);
        qc_next = (bias >= ttc_pkg::R400_W'(ttc_pkg::DAYS_400Y));
        if (qc_next)
        begin
            r400_next = bias - ttc_pkg::R400_W'(ttc_pkg::DAYS_400Y);
        end
        else
        begin
            r400_next = bias;
        end
        wday_next = ttc_pkg::mod7(18'(day_q) + 18'(ttc_pkg::WDAY_BIAS));
    end

    always_ff @(posedge clk)
    begin
        qc3_reg   <= qc_next;
        r400_reg  <= r400_next;
        wday3_reg <= wday_next;
        rsec_reg  <= {day_r, lo2_reg};
    end

    // ---- Stage four ----
    // A quotient of four centuries never arises from these compares, which
    // keeps the leap day in the last century.
    always_comb
    begin
        if (r400_reg >= ttc_pkg::R400_W'(3 * ttc_pkg::DAYS_100Y))
        begin
            cc_next = 2'd3;
        end
        else if (r400_reg >= ttc_pkg::R400_W'(2 * ttc_pkg::DAYS_100Y))
        begin
            cc_next = 2'd2;
        end
        else if (r400_reg >= ttc_pkg::R400_W'(ttc_pkg::DAYS_100Y))
        begin
            cc_next = 2'd1;
        end
        else
        begin
            cc_next = 2'd0;
        end
        r100_full = r400_reg - ttc_pkg::R400_W'(cc_next * ttc_pkg::DAYS_100Y);
    end

    always_ff @(posedge clk)
    begin
        qc4_reg   <= qc3_reg;
        cc4_reg   <= cc_next;
        r100_reg  <= r100_full[ttc_pkg::R100_W-1:0];
        wday4_reg <= wday3_reg;
    end

    ttc_cdiv #(
        .XW      (ttc_pkg::RSEC_W),
        .QW      (ttc_pkg::HOUR_W),
        .RW      (ttc_pkg::HREM_W),
        .DIVISOR (ttc_pkg::SECS_PER_HR)
    ) u_hour_div (
        .clk (clk),
        .x   (rsec_reg),
        .q   (hour_q),
        .r   (hour_r)
    );

    // ---- Stages five and six ----
    ttc_cdiv #(
        .XW      (ttc_pkg::R100_W),
        .QW      (ttc_pkg::QQ_W),
        .RW      (ttc_pkg::R4_W),
        .DIVISOR (ttc_pkg::DAYS_4Y)
    ) u_quad_div (
        .clk (clk),
        .x   (r100_reg),
        .q   (qq),
        .r   (r4)
    );

    ttc_cdiv #(
        .XW      (ttc_pkg::HREM_W),
        .QW      (ttc_pkg::MIN_W),
        .RW      (ttc_pkg::SEC_W),
        .DIVISOR (ttc_pkg::SECS_PER_MIN)
    ) u_min_div (
        .clk (clk),
        .x   (hour_r),
        .q   (min_q),
        .r   (sec_r)
    );

    always_ff @(posedge clk)
    begin
        qc5_reg   <= qc4_reg;
        cc5_reg   <= cc4_reg;
        wday5_reg <= wday4_reg;
        qc6_reg   <= qc5_reg;
        cc6_reg   <= cc5_reg;
        wday6_reg <= wday5_reg;
        hour6_reg <= hour_q;
    end

    // ---- Stage seven ----
    // As with centuries, the compares cap the year at three so that the
    // fourth year of a cycle keeps its leap day.
    always_comb
    begin
        if (r4 >= ttc_pkg::R4_W'(3 * ttc_pkg::DAYS_1Y))
        begin
            ry = 2'd3;
        end
        else if (r4 >= ttc_pkg::R4_W'(2 * ttc_pkg::DAYS_1Y))
        begin
            ry = 2'd2;
        end
        else if (r4 >= ttc_pkg::R4_W'(ttc_pkg::DAYS_1Y))
        begin
            ry = 2'd1;
        end
        else
        begin
            ry = 2'd0;
        end
        rday_next = ttc_pkg::RDAY_W'(r4 - ttc_pkg::R4_W'(ry * ttc_pkg::DAYS_1Y));
        leap_next = (ry == 2'd0) && ((qq != '0) || (cc6_reg == 2'd0));
        year_next = (qc6_reg ? ttc_pkg::YEAR_W'(ttc_pkg::YEAR_BASE_HI)
                             : ttc_pkg::YEAR_W'(ttc_pkg::YEAR_BASE_LO))
                  + ttc_pkg::YEAR_W'(cc6_reg * 100)
                  + ttc_pkg::YEAR_W'({qq, 2'b00})
                  + ttc_pkg::YEAR_W'(ry);
    end

    always_ff @(posedge clk)
    begin
        year7_reg <= year_next;
        rday7_reg <= rday_next;
        leap7_reg <= leap_next;
        wday7_reg <= wday6_reg;
        hour7_reg <= hour6_reg;
    end

    // ---- Stage eight ----
    always_comb
    begin
        midx_next = '0;
        for (int k = 1; k < 12; k++)
        begin
            if (ttc_pkg::month_start(ttc_pkg::MIDX_W'(k)) <= rday7_reg)
            begin
                midx_next = midx_next + ttc_pkg::MIDX_W'(1);
            end
        end
        ysum = 10'(rday7_reg) + 10'(ttc_pkg::DAYS_JAN_FEB) + 10'(leap7_reg);
        ylim = 10'(ttc_pkg::DAYS_1Y) + 10'(leap7_reg);
        if (ysum >= ylim)
        begin
            yday_next = 9'(ysum - ylim);
        end
        else
        begin
            yday_next = 9'(ysum);
        end
    end

    always_ff @(posedge clk)
    begin
        year8_reg <= year7_reg;
        midx8_reg <= midx_next;
        rday8_reg <= rday7_reg;
        yday8_reg <= yday_next;
        wday8_reg <= wday7_reg;
        hour8_reg <= hour7_reg;
        min8_reg  <= min_q;
        sec8_reg  <= sec_r;
    end

    // ---- Output stage ----
    // January and February belong to the next year of the March-based count.
    always_comb
    begin
        jan_feb       = (midx8_reg >= ttc_pkg::MIDX_W'(ttc_pkg::MIDX_JAN));
        year_out_next = year8_reg + 12'(jan_feb);
        if (jan_feb)
        begin
            month_out_next = midx8_reg - 4'(ttc_pkg::MIDX_JAN - 1);
        end
        else
        begin
            month_out_next = midx8_reg + 4'd3;
        end
        dom_out_next = 5'(rday8_reg - ttc_pkg::month_start(midx8_reg) + 9'd1);
    end

    always_ff @(posedge clk)
    begin
        year_reg   <= year_out_next;
        month_reg  <= month_out_next;
        dom_reg    <= dom_out_next;
        hour_reg   <= hour8_reg;
        minute_reg <= min8_reg;
        second_reg <= sec8_reg;
        wday_reg   <= wday8_reg;
        yday_reg   <= yday8_reg;
    end

    assign done         = vld_reg[LAT-1];
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign day_of_week  = wday_reg;
    assign day_of_year  = yday_reg;

endmodule

>>> src/ttc_checker.sv
// ----------------------------------------------------------------------------
// Calendar converter checker
// Port-level checks on beat timing and on the ranges of the result fields.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day_of_month,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic [2:0]  day_of_week,
    input logic [8:0]  day_of_year
);

    logic date_ok;
    logic time_ok;

    assign date_ok = (month >= 4'd1) && (month <= 4'd12) && (day_of_month >= 5'd1)
                  && (year >= 12'd1970) && (year <= 12'd2106);
    assign time_ok = (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59)
                  && (day_of_week <= 3'd6) && (day_of_year <= 9'd365);

    // The pipeline never refuses a beat.
    `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

    // Every accepted beat must be followed later by a result under done.
    `ASSERT_IMPLY(a_latency, clk, rst_n, start && !busy, ##9 done)

    `ASSERT_IMPLY(a_date_range, clk, rst_n, done, date_ok)

    `ASSERT_IMPLY(a_time_range, clk, rst_n, done, time_ok)

endmodule

bind timestamp_to_calendar ttc_checker u_ttc_checker (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Calendar converter testbench
// Sends Unix timestamps into timestamp_to_calendar and checks each date beat
// against an in-bench calendar predictor. Directed stamps cover the range ends,
// leap days, century and epoch boundaries. Random stamps follow, some uniform and some
// drawn around midnights, New Year and end of February, with random gaps between beats.
// ----------------------------------------------------------------------------
module tb;

    localparam int  NUM_RANDOM   = 1750;
    localparam int  LIMIT_CYCLES = 100000;
    localparam int  DRAIN_CYCLES = 20;
    // Seconds from 1970-01-01 to 2000-03-01, the first day after a leap day.
    localparam longint MARCH_2000 = 64'd951868800;
    localparam longint DAY_SECS   = 64'd86400;
    localparam longint DAYS_400   = 64'd146097;
    localparam longint DAYS_100   = 64'd36524;
    localparam longint DAYS_QUAD  = 64'd1461;
    localparam longint LAST_DAY   = 64'd49709;

    typedef struct packed {
        logic [31:0] stamp;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  day_of_week;
        logic [8:0]  day_of_year;
    } calendar_t;

    class calendar_scoreboard;
        calendar_t pending_dates[$];
        int        stamps_taken;
        int        dates_checked;
        int        errors;

        function calendar_t to_calendar(logic [31:0] ts);
            calendar_t c;
            longint    secs, days, tod, wday, qc, rd, cc, qq, ry, leap, yday, years, mon;
            int        mlen[12];
            int        m;
            mlen = '{31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 31, 29};
            secs = longint'(ts) - MARCH_2000;
            days = secs / DAY_SECS;
            tod  = secs % DAY_SECS;
            // Stamps before March 2000 give a negative count; round toward minus infinity.
            if (tod < 0) begin
                tod  += DAY_SECS;
                days -= 1;
            end
            wday = (3 + days) % 7;
            if (wday < 0) begin
                wday += 7;
            end
            qc = days / DAYS_400;
            rd = days % DAYS_400;
            if (rd < 0) begin
                rd += DAYS_400;
                qc -= 1;
            end
            // The last century, quad and year of each cycle hold the extra leap day.
            cc = rd / DAYS_100;
            if (cc == 4) begin
                cc = 3;
            end
            rd -= cc * DAYS_100;
            qq = rd / DAYS_QUAD;
            if (qq == 25) begin
                qq = 24;
            end
            rd -= qq * DAYS_QUAD;
            ry = rd / 365;
            if (ry == 4) begin
                ry = 3;
            end
            rd -= ry * 365;
            leap = (ry == 0 && (qq != 0 || cc == 0)) ? 1 : 0;
            yday = rd + 59 + leap;
            if (yday >= 365 + leap) begin
                yday -= 365 + leap;
            end
            years = 2000 + ry + 4 * qq + 100 * cc + 400 * qc;
            m = 0;
            while (m < 11 && mlen[m] <= rd) begin
                rd -= mlen[m];
                m++;
            end
            mon = m + 2;
            if (mon >= 12) begin
                mon   -= 12;
                years += 1;
            end
            c.stamp        = ts;
            c.year         = years[11:0];
            c.month        = 4'(mon + 1);
            c.day_of_month = 5'(rd + 1);
            c.hour         = 5'(tod / 3600);
            c.minute       = 6'((tod / 60) % 60);
            c.second       = 6'(tod % 60);
            c.day_of_week  = wday[2:0];
            c.day_of_year  = yday[8:0];
            return c;
        endfunction

        function void note_stamp(logic [31:0] ts);
            pending_dates.push_back(to_calendar(ts));
            stamps_taken++;
        endfunction

        function void field_ok(string name, logic [31:0] ts, int want, int got);
            if (want != got) begin
                $display("%0t: stamp %0d %s expected %0d got %0d", $time, ts, name, want, got);
                errors++;
            end
        endfunction

        function void check_date(calendar_t got);
            calendar_t want;
            if (pending_dates.size() == 0) begin
                $display("%0t: date beat with no stamp outstanding (expected none, got %0d-%0d-%0d)",
                         $time, got.year, got.month, got.day_of_month);
                errors++;
                return;
            end
            want = pending_dates.pop_front();
            dates_checked++;
            field_ok("year",         want.stamp, int'(want.year),         int'(got.year));
            field_ok("month",        want.stamp, int'(want.month),        int'(got.month));
            field_ok("day_of_month", want.stamp, int'(want.day_of_month),
                     int'(got.day_of_month));
            field_ok("hour",         want.stamp, int'(want.hour),         int'(got.hour));
            field_ok("minute",       want.stamp, int'(want.minute),       int'(got.minute));
            field_ok("second",       want.stamp, int'(want.second),       int'(got.second));
            field_ok("day_of_week",  want.stamp, int'(want.day_of_week),
                     int'(got.day_of_week));
            field_ok("day_of_year",  want.stamp, int'(want.day_of_year),
                     int'(got.day_of_year));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] timestamp = '0;
    logic        busy;
    logic        done;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  day_of_week;
    logic [8:0]  day_of_year;

    calendar_scoreboard sb = new();
    int cycles = 0;

    timestamp_to_calendar dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .timestamp    (timestamp),
        .done         (done),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second),
        .day_of_week  (day_of_week),
        .day_of_year  (day_of_year)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
            $display("timestamp_to_calendar regression: fail");
            $finish;
        end
    end

    // Values read here are the ones that stood before the edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                sb.note_stamp(timestamp);
            end
            if (done) begin
                sb.check_date(calendar_t'{timestamp, year, month, day_of_month, hour, minute,
                                          second, day_of_week, day_of_year});
            end
        end
    end

    // Start stays high straight into the next beat when no gap is drawn.
    task automatic send_stamp(input logic [31:0] ts, input int gap);
        if (gap > 0) begin
            start     <= 1'b0;
            timestamp <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        timestamp <= ts;
        do begin
            @(posedge clk);
        end while (busy);
    endtask

    function automatic longint time_of_day();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return DAY_SECS - 1;
            default: return longint'($urandom_range(0, 86399));
        endcase
    endfunction

    initial begin
        logic [31:0] directed[$];
        longint      dnum, yr, prior, stamp;
        int          gap;
        bit          steady;
        directed = '{32'd0, 32'd86399, 32'd86400, 32'd68169600, 32'd68255999,
                     32'd915148799, 32'd946684799, 32'd946684800, 32'd951782399,
                     32'd951782400, 32'd951868799, 32'd951868800, 32'd978307199,
                     32'd1078012800, 32'd1078099199, 32'd2147483647, 32'd2147483648,
                     32'd4102444800, 32'd4107542399, 32'd4107542400, 32'd4133980799,
                     32'd4133980800, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF};
        steady = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k]) begin
            send_stamp(directed[k], $urandom_range(0, 14));
        end

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 64 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            gap = steady ? 0 : $urandom_range(0, 14);
            case ($urandom_range(0, 4))
                0, 1: begin
                    stamp = longint'($urandom);
                end
                2: begin
                    dnum  = longint'($urandom_range(0, 49709));
                    stamp = dnum * DAY_SECS + time_of_day();
                end
                default: begin
                    // Land near New Year or the end of February of a random year.
                    yr    = longint'($urandom_range(1971, 2105));
                    prior = yr - 1;
                    dnum  = 365 * (yr - 1970) + (prior / 4 - prior / 100 + prior / 400) - 477;
                    dnum  = dnum + longint'($urandom_range(0, 61)) - 1;
                    if (dnum > LAST_DAY) begin
                        dnum = LAST_DAY;
                    end
                    stamp = dnum * DAY_SECS + time_of_day();
                end
            endcase
            send_stamp(stamp[31:0], gap);
        end
        start <= 1'b0;

        while (sb.pending_dates.size() > 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d timestamps from 1970 to 2106; %0d dates compared, %0d mismatches.",
                 sb.stamps_taken, sb.dates_checked, sb.errors);
        if (sb.errors == 0 && sb.pending_dates.size() == 0) begin
            $display("timestamp_to_calendar regression: pass");
        end
        else begin
            $display("timestamp_to_calendar regression: fail");
        end
        $finish;
    end

endmodule
